// ----- hw/rtl/tlw_pkg.sv -----
// ----------------------------------------------------------------------------
// tlw_pkg
// Shared types, constants and the glyph measure function of the line wrapper.
// ----------------------------------------------------------------------------
package tlw_pkg;

	// Default and largest line count
	localparam int unsigned MAX_LINES_DEFAULT = 64;
	localparam int unsigned MAX_LINES_LIMIT   = 127;

	// Command queue between front and back
	localparam int unsigned Q_DEPTH = 2;

	// Configuration register indexes
	localparam logic [1:0] REG_MAX_WIDTH    = 2'd0;
	localparam logic [1:0] REG_CHAR_SPACING = 2'd1;

	// Reset values of the configuration registers
	localparam logic [15:0] MAX_WIDTH_RESET    = 16'hFFFF;
	localparam logic [15:0] CHAR_SPACING_RESET = 16'h0000;

	// Input opcodes
	localparam logic OP_PLACE  = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	// Result kinds
	localparam logic KIND_CHAR     = 1'b0;
	localparam logic KIND_LINE_END = 1'b1;

	// One queued command: an optional line end, then an optional character
	typedef struct packed {
		logic       has_end;
		logic       has_char;
		logic [7:0] ch;
	} tlw_cmd_t;

	// Result of measuring one glyph against the line state
	typedef struct packed {
		logic [15:0] w;
		logic [8:0]  rem;
		logic        pend;
	} tlw_meas_t;

	// Width after one glyph, clamped to 0..65535, with the new line state
	function automatic tlw_meas_t tlw_measure(
		input logic [15:0] base,
		input logic [8:0]  rem,
		input logic        pend,
		input logic        present,
		input logic [7:0]  offset,
		input logic [7:0]  advance,
		input logic [15:0] spacing
	);
		logic [16:0] acc;
		logic [8:0]  whole;
		logic        round_up;
		logic [18:0] sum;
		tlw_meas_t   m;
		m.rem    = rem;
		m.pend   = pend;
		m.w      = base;
		sum      = {3'b000, base};
		// signed fraction accumulator, whole part truncated toward zero
		acc      = {spacing[15], spacing} + {{8{rem[8]}}, rem};
		round_up = acc[16] && (acc[7:0] != 8'h00);
		whole    = acc[16:8] + {8'h00, round_up};
		if (present) begin
			if (pend) begin
				m.pend = 1'b0;
				if (!offset[7] && offset != 8'h00) begin
					sum = sum + {11'h000, offset};
				end
			end else begin
				sum   = sum + {{10{whole[8]}}, whole};
				m.rem = {round_up, acc[7:0]};
			end
			sum = sum + {11'h000, advance};
		end
		// clamp to the 16 bit range
		if (sum[18]) begin
			m.w = 16'h0000;
		end else if (sum[17:16] != 2'b00) begin
			m.w = 16'hFFFF;
		end else begin
			m.w = sum[15:0];
		end
		return m;
	endfunction

endpackage

// ----- hw/rtl/tlw_front.sv -----
// ----------------------------------------------------------------------------
// tlw_front
// Accepts items, holds the line state and the configuration registers, and
// turns each item into at most one queued command.
// ----------------------------------------------------------------------------
module tlw_front #(
	parameter int unsigned MaxLines = tlw_pkg::MAX_LINES_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             opcode,
	input  logic [7:0]       char_code,
	input  logic             glyph_present,
	input  logic [7:0]       glyph_left_offset,
	input  logic [7:0]       glyph_advance,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	input  logic             q_full,
	output logic             q_push,
	output tlw_pkg::tlw_cmd_t q_cmd
);

	localparam int unsigned LW = $clog2(MaxLines + 1);

	logic [15:0]   max_width_q;
	logic [15:0]   char_spacing_q;
	logic [15:0]   width_q;
	logic [8:0]    rem_q;
	logic          pend_q;
	logic [LW-1:0] lines_q;

	logic              accept;
	logic              lines_left;
	logic              last_line;
	tlw_pkg::tlw_meas_t m_cur;
	tlw_pkg::tlw_meas_t m_new;
	logic              fits;

	assign in_stall  = q_full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !q_full;

	// Measure on the current line and on a fresh line
	assign m_cur = tlw_pkg::tlw_measure(width_q, rem_q, pend_q, glyph_present,
		glyph_left_offset, glyph_advance, char_spacing_q);
	assign m_new = tlw_pkg::tlw_measure(16'h0000, 9'h000, 1'b1, glyph_present,
		glyph_left_offset, glyph_advance, char_spacing_q);

	assign lines_left = lines_q < LW'(MaxLines);
	assign last_line  = (lines_q + LW'(1)) == LW'(MaxLines);
	assign fits       = (m_cur.w < max_width_q) || pend_q;

	// Classify the item into a command
	always_comb begin
		q_push = 1'b0;
		q_cmd  = '{has_end: 1'b0, has_char: 1'b0, ch: 8'h00};
		if (accept && lines_left) begin
			q_push = 1'b1;
			if (opcode == tlw_pkg::OP_FINISH) begin
				q_cmd.has_end = 1'b1;
			end else if (fits) begin
				q_cmd.has_char = 1'b1;
				q_cmd.ch       = char_code;
			end else begin
				q_cmd.has_end  = 1'b1;
				q_cmd.has_char = !last_line;
				q_cmd.ch       = char_code;
			end
		end
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_width_q    <= tlw_pkg::MAX_WIDTH_RESET;
			char_spacing_q <= tlw_pkg::CHAR_SPACING_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == tlw_pkg::REG_MAX_WIDTH) begin
				max_width_q <= cfg_data;
			end else if (cfg_index == tlw_pkg::REG_CHAR_SPACING) begin
				char_spacing_q <= cfg_data;
			end
		end
	end

	// Advance the line state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0;
			rem_q   <= '0;
			pend_q  <= 1'b1;
			lines_q <= '0;
		end else if (accept) begin
			if (opcode == tlw_pkg::OP_FINISH) begin
				width_q <= '0;
				rem_q   <= '0;
				pend_q  <= 1'b1;
				lines_q <= '0;
			end else if (lines_left) begin
				if (fits) begin
					width_q <= m_cur.w;
					rem_q   <= m_cur.rem;
					pend_q  <= m_cur.pend;
				end else begin
					lines_q <= lines_q + LW'(1);
					if (last_line) begin
						width_q <= '0;
						rem_q   <= '0;
						pend_q  <= 1'b1;
					end else begin
						width_q <= m_new.w;
						rem_q   <= m_new.rem;
						pend_q  <= m_new.pend;
					end
				end
			end
		end
	end

endmodule

// ----- hw/rtl/tlw_queue.sv -----
// ----------------------------------------------------------------------------
// tlw_queue
// Short command FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module tlw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tlw_pkg::tlw_cmd_t push_cmd,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output tlw_pkg::tlw_cmd_t head
);

	localparam int unsigned PW = $clog2(tlw_pkg::Q_DEPTH);

	tlw_pkg::tlw_cmd_t entry_q [tlw_pkg::Q_DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [PW:0]       count_q;

	assign full      = count_q == (PW + 1)'(tlw_pkg::Q_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = entry_q[rd_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(tlw_pkg::Q_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(tlw_pkg::Q_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW + 1)'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/tlw_back.sv -----
// ----------------------------------------------------------------------------
// tlw_back
// Expands each queued command into one or two results through an output
// register.
// ----------------------------------------------------------------------------
module tlw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_not_empty,
	input  tlw_pkg::tlw_cmd_t q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic [7:0]        out_char,
	output logic              last_of_run
);

	logic       valid_q;
	logic       end_done_q;
	logic       kind_q;
	logic [7:0] char_q;
	logic       last_q;

	logic       load;
	logic       take_end;

	assign out_valid   = valid_q;
	assign kind        = kind_q;
	assign out_char    = char_q;
	assign last_of_run = last_q;

	// Output register free and a command waiting
	assign load     = q_not_empty && (!valid_q || !out_stall);
	assign take_end = q_head.has_end && !end_done_q;
	assign q_pop    = load && (!take_end || !q_head.has_char);

	// Hold control state of the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			end_done_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q    <= 1'b1;
				end_done_q <= take_end && q_head.has_char;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (take_end) begin
				kind_q <= tlw_pkg::KIND_LINE_END;
				char_q <= 8'h00;
				last_q <= !q_head.has_char;
			end else begin
				kind_q <= tlw_pkg::KIND_CHAR;
				char_q <= q_head.ch;
				last_q <= 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/text_line_wrap_flow_top.sv -----
// ----------------------------------------------------------------------------
// text_line_wrap_flow_top
// Greedy line wrapper: breaks a character stream into lines narrower than
// max_width pixels (a line's first glyph always fits) and emits placed characters and line ends.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_stall  opcode, char_code, glyph_present,
//                                 glyph_left_offset, glyph_advance
//   out      out_valid/ out_stall kind, out_char, last_of_run
//   cfg      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// The front measures and classifies an item in the cycle it is accepted and
// pushes at most one command into a two-entry queue; it takes one item per
// cycle while the queue has room. The back sends one result per cycle while
// out_stall is low, so a wrap (line end plus character) costs the back two
// results; sustained rate is one item per cycle without wraps.
// Reset puts max_width at 65535, char_spacing at 0 and clears the line state.
// A stall on the output fills the queue, then raises in_stall.
// ----------------------------------------------------------------------------
module text_line_wrap_flow_top #(
	parameter int unsigned MaxLines = tlw_pkg::MAX_LINES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  char_code,
	input  logic        glyph_present,
	input  logic [7:0]  glyph_left_offset,
	input  logic [7:0]  glyph_advance,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  out_char,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic              q_full;
	logic              q_push;
	logic              q_pop;
	logic              q_not_empty;
	tlw_pkg::tlw_cmd_t q_cmd;
	tlw_pkg::tlw_cmd_t q_head;

	// Classify items and keep the line state
	tlw_front #(
		.MaxLines(MaxLines)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.opcode            (opcode),
		.char_code         (char_code),
		.glyph_present     (glyph_present),
		.glyph_left_offset (glyph_left_offset),
		.glyph_advance     (glyph_advance),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.q_full            (q_full),
		.q_push            (q_push),
		.q_cmd             (q_cmd)
	);

	// Decouple front and back
	tlw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Emit results
	tlw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

endmodule
